// ----- src/binary_to_decimal_ascii_top_assert.svh -----
// Assertion macros used by the converter RTL.
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BDASC_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BDASC_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/bdasc_pkg.sv -----
package bdasc_pkg;

   localparam int DIGIT_W      = 4;
   localparam int CHAR_W       = 6;
   localparam int VALUE_PORT_W = 32;
   localparam int RSP_TDATA_W  = 8;
   localparam int WIDE_W       = 64;

   localparam logic [CHAR_W-1:0]  ASCII_ZERO   = 6'd48;
   localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
   localparam logic [DIGIT_W-1:0] DABBLE_ADJ   = 4'd3;

   // Per-cycle command to every digit cell.
   typedef struct packed {
      logic clear;   // zero the digit
      logic dabble;  // add-3 correction, then shift one binary bit in
      logic shift;   // take the lower neighbor's digit
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

endpackage

// ----- src/bdasc_cell.sv -----
module bdasc_cell (
   input  logic                           clock,
   input  bdasc_pkg::cell_ctrl_type       ctrl,
   input  logic                           carry_in,
   input  logic [bdasc_pkg::DIGIT_W-1:0]  digit_in,
   output logic [bdasc_pkg::DIGIT_W-1:0]  digit_q,
   output logic                           carry_out
);
   import bdasc_pkg::*;

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in_next;
   logic [DIGIT_W-1:0] adj;

   // Correct a digit of five or more so the doubling carries into the next cell.
   always_comb begin
      adj = (digit_ff >= DABBLE_LIMIT) ? (digit_ff + DABBLE_ADJ) : digit_ff;
   end

   assign carry_out = adj[DIGIT_W-1];
   assign digit_q   = digit_ff;

   always_comb begin
      if (ctrl.clear) begin
         digit_in_next = '0;
      end else if (ctrl.dabble) begin
         digit_in_next = {adj[DIGIT_W-2:0], carry_in};
      end else if (ctrl.shift) begin
         digit_in_next = digit_in;
      end else begin
         digit_in_next = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_next;
   end

endmodule

// ----- src/binary_to_decimal_ascii_top.sv -----
// Binary to decimal ASCII converter. Each input beat carries an unsigned
// number in req_tdata; the low VALUE_BITS bits are converted and the rest
// ignored. The block answers with one output beat per decimal digit, most
// significant first, as the ASCII code '0'..'9' in rsp_tdata; the least
// significant digit carries rsp_tlast. Leading zeros are dropped, so zero
// gives the single beat '0'. If a number needs more than MAX_DIGITS digits,
// only its MAX_DIGITS low digits are sent, leading zeros included. The
// conversion runs in a row of MAX_DIGITS BCD cells by shift-and-add-3: the
// binary word moves into the lowest cell one bit per cycle. The same row then
// shifts toward the top cell, one digit per cycle while the output port
// accepts: leading zeros are dropped there without a beat, and the others
// leave on the output port as it accepts them. One item is handled at a
// time, so a new number is taken only after the last digit of the one before
// has left. No state survives from one item to the next.
`include "binary_to_decimal_ascii_top_assert.svh"

module binary_to_decimal_ascii_top #(
   parameter int VALUE_BITS = 32,
   parameter int MAX_DIGITS = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bdasc_pkg::VALUE_PORT_W-1:0] req_tdata,   // [31:0] value
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bdasc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,   // [5:0] digit_char, [7:6] zero
   output logic                               rsp_tlast    // last_digit
);
   import bdasc_pkg::*;

   localparam int BitCntW = $clog2(VALUE_BITS);
   localparam int RemW    = $clog2(MAX_DIGITS + 1);

   state_type               state_ff, state_in;
   logic [VALUE_BITS-1:0]   bin_ff, bin_in;
   logic [BitCntW-1:0]      bit_cnt_ff, bit_cnt_in;
   logic [RemW-1:0]         remain_ff, remain_in;
   logic                    ovf_ff, ovf_in;       // digits lost off the top cell
   logic                    started_ff, started_in; // a digit was already sent

   cell_ctrl_type           ctrl;
   logic [WIDE_W-1:0]       req_wide;
   logic [DIGIT_W-1:0]      digit_q [MAX_DIGITS];
   logic                    carry_q [MAX_DIGITS];
   logic [DIGIT_W-1:0]      top_digit;
   logic [CHAR_W-1:0]       rsp_char;
   logic                    show;

   // Zero-extend the port so any VALUE_BITS up to 64 can take its slice.
   assign req_wide = WIDE_W'(req_tdata);

   // Row of BCD cells; cell 0 holds the least significant digit.
   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
      if (i == 0) begin : g_low
         bdasc_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .carry_in  (bin_ff[VALUE_BITS-1]),
            .digit_in  ({DIGIT_W{1'b0}}),
            .digit_q   (digit_q[i]),
            .carry_out (carry_q[i])
         );
      end else begin : g_up
         bdasc_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .carry_in  (carry_q[i-1]),
            .digit_in  (digit_q[i-1]),
            .digit_q   (digit_q[i]),
            .carry_out (carry_q[i])
         );
      end
   end

   assign top_digit = digit_q[MAX_DIGITS-1];
   assign rsp_char  = ASCII_ZERO + CHAR_W'(top_digit);
   assign rsp_tdata = RSP_TDATA_W'(rsp_char);
   assign rsp_tlast = (remain_ff == RemW'(1));

   // Send the top digit once it is significant: after overflow, after the
   // first sent digit, when nonzero, or when it is the units digit.
   assign show = ovf_ff || started_ff || (top_digit != '0) || (remain_ff == RemW'(1));

   always_comb begin
      state_in   = state_ff;
      bin_in     = bin_ff;
      bit_cnt_in = bit_cnt_ff;
      remain_in  = remain_ff;
      ovf_in     = ovf_ff;
      started_in = started_ff;
      ctrl       = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctrl.clear = 1'b1;
               bin_in     = req_wide[VALUE_BITS-1:0];
               bit_cnt_in = BitCntW'(VALUE_BITS - 1);
               ovf_in     = 1'b0;
               started_in = 1'b0;
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            // Advance one binary bit into the cell row.
            ctrl.dabble = 1'b1;
            bin_in      = {bin_ff[VALUE_BITS-2:0], 1'b0};
            if (carry_q[MAX_DIGITS-1]) begin
               ovf_in = 1'b1;
            end
            if (bit_cnt_ff == '0) begin
               remain_in = RemW'(MAX_DIGITS);
               state_in  = ST_EMIT;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            rsp_tvalid = show;
            // Drop a leading zero at once; hold a shown digit until taken.
            if (!show || rsp_tready) begin
               ctrl.shift = 1'b1;
               remain_in  = remain_ff - 1'b1;
               if (show) begin
                  started_in = 1'b1;
               end
               if (remain_ff == RemW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bit_cnt_ff <= '0;
         remain_ff  <= '0;
         ovf_ff     <= 1'b0;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
         remain_ff  <= remain_in;
         ovf_ff     <= ovf_in;
         started_ff <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
   end

   `BDASC_ASSERT_IMP(a_one_side, clock, reset, rsp_tvalid, !req_tready, "input taken while sending digits")
   `BDASC_ASSERT_NXT(a_last_frees, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, req_tready, "not ready after last digit")
   `BDASC_ASSERT_NXT(a_accept_conv, clock, reset, req_tvalid && req_tready, (state_ff == ST_CONVERT) && !ovf_ff && !started_ff, "bad start of conversion")
   `BDASC_ASSERT_IMP(a_emit_count, clock, reset, state_ff == ST_EMIT, remain_ff != '0, "digit count ran out while sending")

endmodule
